@@ hdl/shabs_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Shared types, state encoding, round constants and the round functions.
// ----------------------------------------------------------------------------
package shabs_pkg;

    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 61;
    localparam int LEN_W       = 64;
    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS  = 8;
    localparam int ROUNDS      = 64;
    localparam int ROUND_IDX_W = $clog2(ROUNDS);
    localparam int POS_W       = 6;
    localparam int DIGEST_IDX_W = $clog2(HASH_WORDS);

    localparam logic [BYTE_W-1:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [POS_W-1:0]  POS_LAST      = 6'd63;
    localparam logic [POS_W-1:0]  POS_LEN_START = 6'd56;
    localparam logic [2:0]        LEN_LAST_BYTE = 3'd7;
    localparam logic [ROUND_IDX_W-1:0] ROUND_LAST = 6'd63;
    localparam logic [DIGEST_IDX_W-1:0] DIGEST_LAST = 3'd7;

    localparam logic [WORD_W-1:0] HASH_INIT [HASH_WORDS] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                     shift_byte;
        logic [BYTE_W-1:0]        byte_val;
        logic                     step;
    } sched_ctrl_t;

    typedef struct packed {
        logic                     load;
        logic                     step;
        logic                     add;
        logic                     init;
        logic [ROUND_IDX_W-1:0]   round_idx;
        logic [DIGEST_IDX_W-1:0]  rd_idx;
    } round_ctrl_t;

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

@@ hdl/shabs_in_if.sv @@
// ----------------------------------------------------------------------------
// Message byte channel
// Valid/ready channel carrying one message byte and the end-of-message flag.
// ----------------------------------------------------------------------------
interface shabs_in_if;
    logic                          valid;
    logic                          ready;
    logic [shabs_pkg::BYTE_W-1:0]  data_byte;
    logic                          byte_valid;
    logic                          end_of_message;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_message, output ready);
endinterface

@@ hdl/shabs_out_if.sv @@
// ----------------------------------------------------------------------------
// Digest word channel
// Valid/ready channel carrying one digest word with its position.
// ----------------------------------------------------------------------------
interface shabs_out_if;
    logic                                valid;
    logic                                ready;
    logic [shabs_pkg::WORD_W-1:0]        digest_word;
    logic [shabs_pkg::DIGEST_IDX_W-1:0]  word_index;
    logic                                last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

@@ hdl/shabs_sched.sv @@
// ----------------------------------------------------------------------------
// Block buffer and message schedule
// Collects bytes big-endian into a 16-word window and rolls out one
// schedule word per round.
// ----------------------------------------------------------------------------
module shabs_sched (
    input  logic                          clk,
    input  shabs_pkg::sched_ctrl_t        ctrl,
    output logic [shabs_pkg::WORD_W-1:0]  w_head
);

    logic [shabs_pkg::WORD_W-1:0] window_reg  [shabs_pkg::BLOCK_WORDS];
    logic [shabs_pkg::WORD_W-1:0] window_next [shabs_pkg::BLOCK_WORDS];
    logic [shabs_pkg::WORD_W-1:0] w_new;

    // The word sixteen rounds ahead of the one leaving the window.
    assign w_new = shabs_pkg::small_sigma1(window_reg[14]) + window_reg[9]
                 + shabs_pkg::small_sigma0(window_reg[1]) + window_reg[0];

    assign w_head = window_reg[0];

    always_comb
    begin
        for (int i = 0; i < shabs_pkg::BLOCK_WORDS; i++)
        begin
            window_next[i] = window_reg[i];
        end
        if (ctrl.shift_byte)
        begin
            // The whole block moves up one byte so the first byte ends in word 0.
            for (int i = 0; i < shabs_pkg::BLOCK_WORDS - 1; i++)
            begin
                window_next[i] = {window_reg[i][23:0], window_reg[i+1][31:24]};
            end
            window_next[shabs_pkg::BLOCK_WORDS-1] =
                {window_reg[shabs_pkg::BLOCK_WORDS-1][23:0], ctrl.byte_val};
        end
        else if (ctrl.step)
        begin
            for (int i = 0; i < shabs_pkg::BLOCK_WORDS - 1; i++)
            begin
                window_next[i] = window_reg[i+1];
            end
            window_next[shabs_pkg::BLOCK_WORDS-1] = w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < shabs_pkg::BLOCK_WORDS; i++)
        begin
            window_reg[i] <= window_next[i];
        end
    end

endmodule

@@ hdl/shabs_round.sv @@
// ----------------------------------------------------------------------------
// Compression round unit
// Holds the working variables and the chain value; one round per cycle.
// ----------------------------------------------------------------------------
module shabs_round (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shabs_pkg::round_ctrl_t        ctrl,
    input  logic [shabs_pkg::WORD_W-1:0]  w_t,
    output logic [shabs_pkg::WORD_W-1:0]  chain_word
);

    logic [shabs_pkg::WORD_W-1:0] work_reg  [shabs_pkg::HASH_WORDS];
    logic [shabs_pkg::WORD_W-1:0] work_next [shabs_pkg::HASH_WORDS];
    logic [shabs_pkg::WORD_W-1:0] chain_reg [shabs_pkg::HASH_WORDS];
    logic [shabs_pkg::WORD_W-1:0] chain_next [shabs_pkg::HASH_WORDS];
    logic [shabs_pkg::WORD_W-1:0] ch_val;
    logic [shabs_pkg::WORD_W-1:0] maj_val;
    logic [shabs_pkg::WORD_W-1:0] t1;
    logic [shabs_pkg::WORD_W-1:0] t2;

    assign ch_val  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj_val = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                   ^ (work_reg[1] & work_reg[2]);
    assign t1 = work_reg[7] + shabs_pkg::big_sigma1(work_reg[4]) + ch_val
              + shabs_pkg::ROUND_K[ctrl.round_idx] + w_t;
    assign t2 = shabs_pkg::big_sigma0(work_reg[0]) + maj_val;

    assign chain_word = chain_reg[ctrl.rd_idx];

    always_comb
    begin
        for (int i = 0; i < shabs_pkg::HASH_WORDS; i++)
        begin
            work_next[i]  = work_reg[i];
            chain_next[i] = chain_reg[i];
        end
        if (ctrl.load)
        begin
            for (int i = 0; i < shabs_pkg::HASH_WORDS; i++)
            begin
                work_next[i] = chain_reg[i];
            end
        end
        else if (ctrl.step)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
        if (ctrl.init)
        begin
            for (int i = 0; i < shabs_pkg::HASH_WORDS; i++)
            begin
                chain_next[i] = shabs_pkg::HASH_INIT[i];
            end
        end
        else if (ctrl.add)
        begin
            for (int i = 0; i < shabs_pkg::HASH_WORDS; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < shabs_pkg::HASH_WORDS; i++)
        begin
            work_reg[i] <= work_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < shabs_pkg::HASH_WORDS; i++)
            begin
                chain_reg[i] <= shabs_pkg::HASH_INIT[i];
            end
        end
        else
        begin
            for (int i = 0; i < shabs_pkg::HASH_WORDS; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

endmodule

@@ hdl/sha256_byte_stream_hasher_unit.sv @@
// Message bytes are taken one per cycle while the unit is idle; the 64th byte of
// a block holds input ready low through the rounds and the chain update.
// Closing a message shifts in padding and length one byte a cycle plus one or
// two compressions, then eight digest words follow.
// Reset (asynchronous, active low) restores the initial hash and a zero count.
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Sequencer around the block buffer/schedule and the shared round unit.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit (
    input  logic         clk,
    input  logic         rst_n,
    shabs_in_if.sink     msg_in,
    shabs_out_if.source  digest_out
);

    shabs_pkg::state_t      state_reg, state_next;
    logic [shabs_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [shabs_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [shabs_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [2:0]                         len_cnt_reg, len_cnt_next;
    logic [shabs_pkg::ROUND_IDX_W-1:0]  round_reg, round_next;
    logic [shabs_pkg::DIGEST_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic closing_reg, closing_next;
    logic mark_done_reg, mark_done_next;
    logic final_reg, final_next;

    shabs_pkg::sched_ctrl_t sched_ctrl;
    shabs_pkg::round_ctrl_t round_ctrl;
    logic [shabs_pkg::WORD_W-1:0] w_head;
    logic [shabs_pkg::WORD_W-1:0] chain_word;

    shabs_sched u_sched (
        .clk    (clk),
        .ctrl   (sched_ctrl),
        .w_head (w_head)
    );

    shabs_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (round_ctrl),
        .w_t        (w_head),
        .chain_word (chain_word)
    );

    assign msg_in.ready           = (state_reg == shabs_pkg::ST_IDLE);
    assign digest_out.valid       = (state_reg == shabs_pkg::ST_OUT);
    assign digest_out.digest_word = chain_word;
    assign digest_out.word_index  = out_idx_reg;
    assign digest_out.last_word   = (out_idx_reg == shabs_pkg::DIGEST_LAST);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        len_cnt_next   = len_cnt_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        closing_next   = closing_reg;
        mark_done_next = mark_done_reg;
        final_next     = final_reg;

        sched_ctrl.shift_byte = 1'b0;
        sched_ctrl.byte_val   = '0;
        sched_ctrl.step       = 1'b0;
        round_ctrl.load       = 1'b0;
        round_ctrl.step       = 1'b0;
        round_ctrl.add        = 1'b0;
        round_ctrl.init       = 1'b0;
        round_ctrl.round_idx  = round_reg;
        round_ctrl.rd_idx     = out_idx_reg;

        case (state_reg)
            shabs_pkg::ST_IDLE:
            begin
                if (msg_in.valid)
                begin
                    closing_next = msg_in.end_of_message;
                    if (msg_in.byte_valid)
                    begin
                        sched_ctrl.shift_byte = 1'b1;
                        sched_ctrl.byte_val   = msg_in.data_byte;
                        pos_next   = pos_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                        if (pos_reg == shabs_pkg::POS_LAST)
                        begin
                            round_ctrl.load = 1'b1;
                            round_next      = '0;
                            state_next      = shabs_pkg::ST_ROUND;
                        end
                        else if (msg_in.end_of_message)
                        begin
                            state_next = shabs_pkg::ST_PAD_MARK;
                        end
                    end
                    else if (msg_in.end_of_message)
                    begin
                        state_next = shabs_pkg::ST_PAD_MARK;
                    end
                end
            end

            shabs_pkg::ST_ROUND:
            begin
                round_ctrl.step = 1'b1;
                sched_ctrl.step = 1'b1;
                round_next      = round_reg + 1'b1;
                if (round_reg == shabs_pkg::ROUND_LAST)
                begin
                    state_next = shabs_pkg::ST_ADD;
                end
            end

            shabs_pkg::ST_ADD:
            begin
                round_ctrl.add = 1'b1;
                if (!closing_reg)
                begin
                    state_next = shabs_pkg::ST_IDLE;
                end
                else if (final_reg)
                begin
                    out_idx_next = '0;
                    state_next   = shabs_pkg::ST_OUT;
                end
                else if (!mark_done_reg)
                begin
                    state_next = shabs_pkg::ST_PAD_MARK;
                end
                else
                begin
                    state_next = shabs_pkg::ST_PAD_ZERO;
                end
            end

            shabs_pkg::ST_PAD_MARK:
            begin
                sched_ctrl.shift_byte = 1'b1;
                sched_ctrl.byte_val   = shabs_pkg::PAD_MARK_BYTE;
                pos_next       = pos_reg + 1'b1;
                mark_done_next = 1'b1;
                len_next       = {count_reg, 3'b000};
                len_cnt_next   = '0;
                if (pos_reg == shabs_pkg::POS_LAST)
                begin
                    round_ctrl.load = 1'b1;
                    round_next      = '0;
                    state_next      = shabs_pkg::ST_ROUND;
                end
                else
                begin
                    state_next = shabs_pkg::ST_PAD_ZERO;
                end
            end

            shabs_pkg::ST_PAD_ZERO:
            begin
                if (pos_reg == shabs_pkg::POS_LEN_START)
                begin
                    state_next = shabs_pkg::ST_PAD_LEN;
                end
                else
                begin
                    sched_ctrl.shift_byte = 1'b1;
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == shabs_pkg::POS_LAST)
                    begin
                        round_ctrl.load = 1'b1;
                        round_next      = '0;
                        state_next      = shabs_pkg::ST_ROUND;
                    end
                end
            end

            shabs_pkg::ST_PAD_LEN:
            begin
                // Bit length goes out most significant byte first.
                sched_ctrl.shift_byte = 1'b1;
                sched_ctrl.byte_val   = len_reg[shabs_pkg::LEN_W-1 -: shabs_pkg::BYTE_W];
                len_next     = {len_reg[shabs_pkg::LEN_W-shabs_pkg::BYTE_W-1:0],
                                {shabs_pkg::BYTE_W{1'b0}}};
                len_cnt_next = len_cnt_reg + 1'b1;
                pos_next     = pos_reg + 1'b1;
                if (len_cnt_reg == shabs_pkg::LEN_LAST_BYTE)
                begin
                    final_next      = 1'b1;
                    round_ctrl.load = 1'b1;
                    round_next      = '0;
                    state_next      = shabs_pkg::ST_ROUND;
                end
            end

            shabs_pkg::ST_OUT:
            begin
                if (digest_out.ready)
                begin
                    out_idx_next = out_idx_reg + 1'b1;
                    if (out_idx_reg == shabs_pkg::DIGEST_LAST)
                    begin
                        round_ctrl.init = 1'b1;
                        count_next      = '0;
                        pos_next        = '0;
                        closing_next    = 1'b0;
                        mark_done_next  = 1'b0;
                        final_next      = 1'b0;
                        state_next      = shabs_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = shabs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shabs_pkg::ST_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            len_cnt_reg   <= '0;
            round_reg     <= '0;
            out_idx_reg   <= '0;
            closing_reg   <= 1'b0;
            mark_done_reg <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            len_cnt_reg   <= len_cnt_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            closing_reg   <= closing_next;
            mark_done_reg <= mark_done_next;
            final_reg     <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Streams messages of assorted lengths into the hasher, at most one byte per
// transaction, and checks every digest word against a SHA-256 predictor
// kept in a scoreboard. Both channels idle at random, the digest side is
// held off for a long stretch once, and the padding boundaries are targeted.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [shabs_pkg::WORD_W-1:0]       word;
        logic [shabs_pkg::DIGEST_IDX_W-1:0] index;
        logic                               last;
    } digest_entry_t;

    class digest_scoreboard;
        localparam logic [31:0] K_TABLE [64] = '{
            32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
            32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
            32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
            32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
            32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
            32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
            32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
            32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
            32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
            32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
            32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
            32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
            32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
            32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
            32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
            32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
        };
        localparam logic [31:0] IV_TABLE [8] = '{
            32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
            32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
        };

        logic [31:0]   hash_state [8];
        logic [31:0]   msg_block [16];
        logic [60:0]   msg_bytes;
        digest_entry_t expected_words [$];
        int            errors;

        function new();
            errors = 0;
            restart();
            foreach (msg_block[i])
                msg_block[i] = '0;
        endfunction

        function void restart();
            foreach (hash_state[i])
                hash_state[i] = IV_TABLE[i];
            msg_bytes = '0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void place_byte(int pos, logic [7:0] v);
            msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
        endfunction

        function void compress_block();
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
            for (int t = 0; t < 16; t++)
                w[t] = msg_block[t];
            for (int t = 16; t < 64; t++)
                w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                     + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
            a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
            e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
            for (int t = 0; t < 64; t++)
            begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                   + K_TABLE[t] + w[t];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
            hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
        endfunction

        // Called for every accepted input transaction.
        function void note_input(logic [7:0] data, logic has_byte, logic closes);
            int            pos;
            logic [63:0]   bit_len;
            digest_entry_t entry;
            if (has_byte)
            begin
                pos = msg_bytes[5:0];
                place_byte(pos, data);
                msg_bytes = msg_bytes + 1'b1;
                if (pos == 63)
                    compress_block();
            end
            if (!closes)
                return;
            pos = msg_bytes[5:0];
            place_byte(pos, 8'h80);
            for (int k = pos + 1; k < 64; k++)
                place_byte(k, 8'h00);
            // No room left for the length field, so it goes in a block of its own.
            if (pos >= 56)
            begin
                compress_block();
                foreach (msg_block[i])
                    msg_block[i] = '0;
            end
            bit_len = {msg_bytes, 3'b000};
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            compress_block();
            for (int k = 0; k < 8; k++)
            begin
                entry.word  = hash_state[k];
                entry.index = k[2:0];
                entry.last  = (k == 7);
                expected_words.push_back(entry);
            end
            restart();
        endfunction

        // Called for every accepted digest transaction.
        function void check_result(logic [31:0] word, logic [2:0] index, logic last);
            digest_entry_t entry;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected digest word %h index %0d last %b",
                         $time, word, index, last);
                errors++;
                return;
            end
            entry = expected_words.pop_front();
            if (word !== entry.word)
            begin
                $display("%0t: digest_word expected %h actual %h", $time, entry.word, word);
                errors++;
            end
            if (index !== entry.index)
            begin
                $display("%0t: word_index expected %0d actual %0d", $time, entry.index, index);
                errors++;
            end
            if (last !== entry.last)
            begin
                $display("%0t: last_word expected %b actual %b", $time, entry.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    localparam int TARGET_ITEMS = 380;

    logic clk;
    logic rst_n;

    shabs_in_if  msg_if ();
    shabs_out_if dig_if ();

    sha256_byte_stream_hasher_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_in     (msg_if),
        .digest_out (dig_if)
    );

    digest_scoreboard sb = new();
    int  items_sent = 0;
    bit  hold_digest = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        rst_n                 <= 1'b0;
        msg_if.valid          <= 1'b0;
        msg_if.data_byte      <= '0;
        msg_if.byte_valid     <= 1'b0;
        msg_if.end_of_message <= 1'b0;
        dig_if.ready          <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && msg_if.valid && msg_if.ready)
            sb.note_input(msg_if.data_byte, msg_if.byte_valid, msg_if.end_of_message);
        if (rst_n && dig_if.valid && dig_if.ready)
            sb.check_result(dig_if.digest_word, dig_if.word_index, dig_if.last_word);
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Offers one transaction and returns at the edge where it is taken.
    task automatic send_item(input logic [7:0] data, input logic has_byte,
                             input logic closes, input int gap);
        if (gap > 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.data_byte      <= data;
        msg_if.byte_valid     <= has_byte;
        msg_if.end_of_message <= closes;
        do
            @(posedge clk);
        while (!msg_if.ready);
        if (has_byte || closes)
            items_sent++;
    endtask

    task automatic send_message(input int len);
        bit burst;
        bit joint;
        int gap;
        burst = ($urandom_range(0, 3) == 0);
        joint = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            gap = burst ? 0 : idle_gap();
            if ($urandom_range(0, 19) == 0)
                send_item($urandom_range(0, 255), 1'b0, 1'b0, gap);
            send_item($urandom_range(0, 255), 1'b1, joint && (i == len - 1),
                      burst ? 0 : idle_gap());
        end
        if (!joint)
            send_item($urandom_range(0, 255), 1'b0, 1'b1, burst ? 0 : idle_gap());
    endtask

    function automatic int pick_length();
        int edge_lengths [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        if ($urandom_range(0, 99) < 35)
            return edge_lengths[$urandom_range(0, 11)];
        return $urandom_range(1, 70);
    endfunction

    // Digest side: random ready pattern, with one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_digest)
            begin
                hold_digest = 0;
                dig_if.ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            if ($urandom_range(0, 99) < 55)
            begin
                dig_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                dig_if.ready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                    : $urandom_range(1, 3)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message, then an item carrying neither flag.
        send_item(8'h5A, 1'b0, 1'b1, 0);
        send_item(8'hFF, 1'b0, 1'b0, 0);
        // Two one-byte messages, each closed in the same transaction.
        send_item(8'h00, 1'b1, 1'b1, 0);
        send_item(8'hFF, 1'b1, 1'b1, 1);
        // Three bytes closed by a separate end transaction.
        send_item(8'h61, 1'b1, 1'b0, 0);
        send_item(8'h62, 1'b1, 1'b0, 0);
        send_item(8'h63, 1'b1, 1'b0, 2);
        send_item(8'hA5, 1'b0, 1'b1, 0);

        // The sender waits here until every digest word has been drained.
        msg_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);

        hold_digest = 1;
        while (items_sent < TARGET_ITEMS)
        begin
            // The last message is trimmed so the total stays near the target.
            len = pick_length();
            if (len > TARGET_ITEMS - items_sent)
                len = TARGET_ITEMS - items_sent;
            send_message(len);
        end
        msg_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/shabs_pkg.sv
hdl/shabs_in_if.sv
hdl/shabs_out_if.sv
hdl/shabs_sched.sv
hdl/shabs_round.sv
hdl/sha256_byte_stream_hasher_unit.sv
dv/testbench.sv
